FILE: rtl/bb33_pkg.sv
// Shared types, sizes and the reciprocal table of the 3x3 RGBA box blur.
package bb33_pkg;

  localparam int MAX_SIDE = 1024;
  localparam int CH_W = 8;
  localparam int NUM_CH = 4;
  localparam int CFG_W = 11;

  localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int NW = $clog2(MAX_SIDE + 1);
  localparam int ROW_W = $clog2(MAX_SIDE + 2);
  localparam int CLAMP_W = (NW > CFG_W) ? NW : CFG_W;
  localparam int DEFAULT_SIDE = (MAX_SIDE < 64) ? MAX_SIDE : 64;

  localparam int SUM3_W = CH_W + 2;
  localparam int SUM9_W = CH_W + 4;
  localparam int CNT_W = 4;
  localparam int RECIP_W = 16;
  localparam int RECIP_SHIFT = 15;
  localparam int PROD_W = SUM9_W + RECIP_W;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    logic emit;
    logic top;
    logic bot;
    logic left;
    logic right;
    logic done;
  } meta_t;

  typedef struct packed {
    logic   done;
    pixel_t pix;
  } result_t;

  // Multiplier for an exact truncating divide by a neighbourhood count,
  // valid for every sum of up to nine 8-bit values.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      4'd1:    m = 16'd32768;
      4'd2:    m = 16'd16384;
      4'd3:    m = 16'd10923;
      4'd4:    m = 16'd8192;
      4'd6:    m = 16'd5462;
      4'd9:    m = 16'd3641;
      default: m = 16'd32768;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/box_blur_3x3_rgba.sv
// Streaming 3x3 box blur over a square RGBA frame, one pixel per clock while in_stall is low.
// Throughput: one transaction per cycle; input stalls only while eight results are outstanding.
// A result passes through the stage registers and the output queue before it is offered on the output.
// The line store has one registered read port, read at accept and written back in the following cycle.
// Reset (synchronous): clears counters, pipeline valids and the output queue, side back to 64.
// The line store is not cleared; data read from entries the frame has not written yet reach only masked rows.
module box_blur_3x3_rgba
  import bb33_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             kind,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  input  logic [CH_W-1:0]  in_alpha,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CH_W-1:0]  out_red,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_blue,
  output logic [CH_W-1:0]  out_alpha,
  output logic             frame_done,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  // configuration and position counters
  logic [NW-1:0]     side;
  logic [NW-1:0]     side_next;
  logic [ADDR_W-1:0] side_last;
  logic [ADDR_W-1:0] in_col;
  logic [ROW_W-1:0]  in_row;
  logic              emit;
  logic [ADDR_W-1:0] orow;
  logic [ADDR_W-1:0] ocol;

  logic   acc;
  logic   draining;
  logic   take;
  logic   pop;
  pixel_t pix_in;
  meta_t  meta_in;

  // stage 1: line store read data arrives
  line_t             line_mem [MAX_SIDE];
  line_t             rd_q;
  line_t             rd_eff;
  line_t             wr_data;
  logic              s1_valid;
  logic [ADDR_W-1:0] s1_col;
  pixel_t            s1_pix;
  meta_t             s1_meta;
  logic              s1_fwd;
  line_t             s1_fwd_data;

  // window of the three newest columns, index 0 newest
  column_t win [3];

  // stage 2: window complete
  logic  s2_valid;
  meta_t s2_meta;
  logic [NUM_CH-1:0][SUM3_W-1:0] colsum [3];

  // stage 3: column sums
  logic                          s3_valid;
  logic [NUM_CH-1:0][SUM3_W-1:0] s3_colsum [3];
  logic                          s3_left;
  logic                          s3_right;
  logic                          s3_done;
  logic [1:0]                    s3_rows;
  logic [NUM_CH-1:0][SUM9_W-1:0] tot;

  // stage 4: full sums and count
  logic                          s4_valid;
  logic [NUM_CH-1:0][SUM9_W-1:0] s4_sum;
  logic [CNT_W-1:0]              s4_cnt;
  logic                          s4_done;
  logic [NUM_CH-1:0][PROD_W-1:0] prod;
  result_t                       res;

  // output queue
  result_t           fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [OCC_W-1:0]  fcount;
  logic [OCC_W-1:0]  occ;
  result_t           head;

  always_comb begin
    side_next = NW'(cfg_wr_data);
    if (cfg_wr_data == '0) begin
      side_next = NW'(1);
    end else if (CLAMP_W'(cfg_wr_data) > CLAMP_W'(MAX_SIDE)) begin
      side_next = NW'(MAX_SIDE);
    end
  end

  assign side_last = ADDR_W'(side - NW'(1));
  assign in_stall  = (occ == OCC_W'(FIFO_DEPTH));
  assign acc       = in_valid && !in_stall;
  assign draining  = (in_row >= ROW_W'(side));
  // a flush before the frame is complete does nothing
  assign take      = acc && !(kind && !draining);
  assign pix_in    = (kind || draining) ? '0 : {in_alpha, in_blue, in_green, in_red};

  always_comb begin
    meta_in.emit  = emit;
    meta_in.top   = (orow != '0);
    meta_in.bot   = (orow != side_last);
    meta_in.left  = (ocol != '0);
    meta_in.right = (ocol != side_last);
    meta_in.done  = (orow == side_last) && (ocol == side_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side   <= NW'(DEFAULT_SIDE);
      in_col <= '0;
      in_row <= '0;
      emit   <= 1'b0;
      orow   <= '0;
      ocol   <= '0;
    end else if (cfg_wr_en) begin
      side   <= side_next;
      in_col <= '0;
      in_row <= '0;
      emit   <= 1'b0;
      orow   <= '0;
      ocol   <= '0;
    end else if (take) begin
      if (emit && meta_in.done) begin
        // bottom right pixel out: restart the frame
        in_col <= '0;
        in_row <= '0;
        emit   <= 1'b0;
        orow   <= '0;
        ocol   <= '0;
      end else begin
        if (in_col == side_last) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + ADDR_W'(1);
        end
        if ((in_row == ROW_W'(1)) && (in_col == '0)) begin
          emit <= 1'b1;
        end
        if (emit) begin
          if (ocol == side_last) begin
            ocol <= '0;
            orow <= orow + ADDR_W'(1);
          end else begin
            ocol <= ocol + ADDR_W'(1);
          end
        end
      end
    end
  end

  // forward the write of the previous transaction when it hits the same column
  assign rd_eff = s1_fwd ? s1_fwd_data : rd_q;

  always_comb begin
    wr_data.upper  = rd_eff.middle;
    wr_data.middle = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rd_q <= line_mem[in_col];
    end
    if (s1_valid) begin
      line_mem[s1_col] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col      <= in_col;
      s1_pix      <= pix_in;
      s1_meta     <= meta_in;
      s1_fwd      <= s1_valid && (s1_col == in_col);
      s1_fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win[2]     <= win[1];
      win[1]     <= win[0];
      win[0].top <= rd_eff.upper;
      win[0].mid <= rd_eff.middle;
      win[0].bot <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_meta.emit;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_meta <= s1_meta;
    end
  end

  // drop the rows that fall outside the frame
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        colsum[k][ch] = SUM3_W'(win[k].mid[ch])
                      + (s2_meta.top ? SUM3_W'(win[k].top[ch]) : SUM3_W'(0))
                      + (s2_meta.bot ? SUM3_W'(win[k].bot[ch]) : SUM3_W'(0));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      s3_colsum <= colsum;
      s3_left   <= s2_meta.left;
      s3_right  <= s2_meta.right;
      s3_done   <= s2_meta.done;
      s3_rows   <= 2'd1 + {1'b0, s2_meta.top} + {1'b0, s2_meta.bot};
    end
  end

  // the left column is the oldest, the right one the newest
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      tot[ch] = SUM9_W'(s3_colsum[1][ch])
              + (s3_left  ? SUM9_W'(s3_colsum[2][ch]) : SUM9_W'(0))
              + (s3_right ? SUM9_W'(s3_colsum[0][ch]) : SUM9_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      s4_sum  <= tot;
      s4_cnt  <= CNT_W'({2'b00, s3_rows} * (4'd1 + {3'b000, s3_left} + {3'b000, s3_right}));
      s4_done <= s3_done;
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch]    = PROD_W'(s4_sum[ch]) * PROD_W'(recip(s4_cnt));
      res.pix[ch] = prod[ch][RECIP_SHIFT +: CH_W];
    end
    res.done = s4_done;
  end

  assign head       = fifo[rd_ptr];
  assign out_valid  = (fcount != '0);
  assign pop        = out_valid && !out_stall;
  assign out_red    = head.pix[0];
  assign out_green  = head.pix[1];
  assign out_blue   = head.pix[2];
  assign out_alpha  = head.pix[3];
  assign frame_done = head.done;

  always_ff @(posedge clk) begin
    if (s4_valid) begin
      fifo[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fcount <= '0;
      occ    <= '0;
    end else begin
      if (s4_valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      fcount <= fcount + OCC_W'(s4_valid) - OCC_W'(pop);
      // reserve a queue slot for every transaction that will give a result
      occ    <= occ + OCC_W'(take && emit) - OCC_W'(pop);
    end
  end

endmodule

FILE: rtl/bb33_check.sv
// Port-level checks on the 3x3 RGBA box blur, bound to its top level.
module bb33_check
  import bb33_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             kind,
  input logic [CH_W-1:0]  in_red,
  input logic [CH_W-1:0]  in_green,
  input logic [CH_W-1:0]  in_blue,
  input logic [CH_W-1:0]  in_alpha,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CH_W-1:0]  out_red,
  input logic [CH_W-1:0]  out_green,
  input logic [CH_W-1:0]  out_blue,
  input logic [CH_W-1:0]  out_alpha,
  input logic             frame_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green) &&
      $stable(out_blue) && $stable(out_alpha) && $stable(frame_done))
    else $error("output payload changed while stalled");

  // a stalled input transaction must wait unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(kind) && $stable(in_red) &&
      $stable(in_green) && $stable(in_blue) && $stable(in_alpha))
    else $error("input transaction changed while stalled");

  // a result that rises on the output must have been caused by an accepted input transaction
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 5))
    else $error("result appeared without a causing transaction");

  // the input holds off only when results are queued
  a_stall_queued: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind box_blur_3x3_rgba bb33_check u_bb33_check (.*);
